// ----- rtl/core/ndlm_pkg.sv -----
// Shared types, widths and command codes for the name directory.
// No dependencies; the normalizer, the sequencer and the top level import it.
package ndlm_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 1024;
	localparam int unsigned NAME_W          = 64;
	localparam int unsigned IDX_OUT_W       = 10;
	localparam int unsigned TOT_OUT_W       = 11;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic                 full_error;
		logic [TOT_OUT_W-1:0] entry_total;
		logic [IDX_OUT_W-1:0] match_index;
		logic                 found;
	} result_t;

endpackage

// ----- rtl/core/name_directory_last_match_lookup_core.sv -----
// Top level of the name directory: stream ports, normalizer, name RAM, sequencer.
// Depends on ndlm_pkg, ndlm_norm, ndlm_ram and ndlm_seq.
//
//  channel   dir  width  handshake           contents
//  s_*       in   72     s_tvalid/s_tready   command, name_bytes
//  m_*       out  24     m_tvalid/m_tready   found, match_index, entry_total, full_error
//
// Append, clear and the unused command go from accept straight to the result, with no scan.
// A lookup of n held entries scans the name RAM from the top index down, one
// entry per cycle over its single read port, and stops at the first hit.
// One item is in work at a time; s_tready is low until the result transfers.
// Reset clears the entry count and sequencer state; the name RAM needs no clearing pass.
module name_directory_last_match_lookup_core
	import ndlm_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int unsigned IDX_W      = $clog2(MAX_ENTRIES)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] command, [65:2] name_bytes, [71:66] zero
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] found, [10:1] match_index, [21:11] entry_total, [22] full_error, [23] zero
	output logic [23:0] m_tdata
);

	logic [NAME_W-1:0] norm;
	logic              empty;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [NAME_W-1:0] ram_rdata;
	result_t           res;

	ndlm_norm u_norm (
		.raw   (s_tdata[65:2]),
		.norm  (norm),
		.empty (empty)
	);

	ndlm_ram #(
		.WIDTH (NAME_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (norm),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ndlm_seq #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tdata[1:0])),
		.in_norm   (norm),
		.in_empty  (empty),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res};

endmodule

// ----- rtl/core/ndlm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ndlm_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/ndlm_norm.sv -----
// Name normalizer: zero from the first NUL or space on, fold a-z to upper case.
// Depends on ndlm_pkg.
module ndlm_norm
	import ndlm_pkg::*;
(
	input  logic [NAME_W-1:0] raw,
	output logic [NAME_W-1:0] norm,
	output logic              empty
);

	always_comb begin
		logic       stop;
		logic [7:0] b;
		stop = 1'b0;
		norm = '0;
		for (int k = 0; k < 8; k++) begin
			b = raw[8*k +: 8];
			if (b == 8'h00 || b == 8'h20) begin
				stop = 1'b1;
			end
			if (!stop) begin
				if (b >= 8'h61 && b <= 8'h7A) begin
					b = b - 8'd32;
				end
				norm[8*k +: 8] = b;
			end
		end
	end

	// a leading space still counts as a query, only a leading NUL is empty
	assign empty = (raw[7:0] == 8'h00);

endmodule

// ----- rtl/core/ndlm_seq.sv -----
// Command sequencer: entry count, append writes and the downward lookup scan
// through the single name comparator. Depends on ndlm_pkg.
module ndlm_seq
	import ndlm_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int unsigned IDX_W      = $clog2(MAX_ENTRIES),
	localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmd_t              in_cmd,
	input  logic [NAME_W-1:0] in_norm,
	input  logic              in_empty,
	output logic              ram_we,
	output logic [IDX_W-1:0]  ram_waddr,
	output logic              ram_re,
	output logic [IDX_W-1:0]  ram_raddr,
	input  logic [NAME_W-1:0] ram_rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_res
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  addr_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic              pend_q;
	logic              last_q;
	logic [NAME_W-1:0] key_q;
	result_t           res_q;

	logic              accept;
	logic              full;
	logic              hit;
	logic              scan_end;
	result_t           acc_res;

	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(MAX_ENTRIES));
	assign hit      = pend_q && (ram_rdata == key_q);
	assign scan_end = hit || (pend_q && last_q);

	function automatic logic [TOT_OUT_W-1:0] total_of(input logic [CNT_W-1:0] c);
		logic [31:0] ext;
		ext = 32'(c);
		return ext[TOT_OUT_W-1:0];
	endfunction

	function automatic logic [IDX_OUT_W-1:0] index_of(input logic [IDX_W-1:0] i);
		logic [31:0] ext;
		ext = 32'(i);
		return ext[IDX_OUT_W-1:0];
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_LOOKUP && !in_empty && count_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_RESP);
		ram_we    = accept && (in_cmd == CMD_APPEND) && !full;
		ram_waddr = count_q[IDX_W-1:0];
		ram_re    = (state_q == ST_SCAN) && !last_q && !hit;
		ram_raddr = addr_q;
		out_res   = res_q;
	end

	// result fields known at accept time; a lookup fills in its match later
	always_comb begin
		acc_res             = '0;
		acc_res.entry_total = total_of(count_q);
		unique case (in_cmd)
			CMD_APPEND: begin
				if (full) begin
					acc_res.full_error = 1'b1;
				end else begin
					acc_res.entry_total = total_of(count_q + 1'b1);
				end
			end
			CMD_CLEAR:  acc_res.entry_total = '0;
			CMD_LOOKUP, CMD_NONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pend_q <= 1'b0;
				last_q <= 1'b0;
				unique case (in_cmd)
					CMD_APPEND: if (!full) count_q <= count_q + 1'b1;
					CMD_CLEAR:  count_q <= '0;
					CMD_LOOKUP, CMD_NONE: ;
					default: ;
				endcase
			end else if (state_q == ST_SCAN && !scan_end) begin
				pend_q <= 1'b1;
				if (addr_q == '0) begin
					last_q <= 1'b1;
				end
			end
		end
	end

	// scan datapath and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= in_norm;
			addr_q <= count_q[IDX_W-1:0] - 1'b1;
			res_q  <= acc_res;
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				res_q <= {res_q.full_error, res_q.entry_total, index_of(cmp_idx_q), 1'b1};
			end else if (!scan_end) begin
				// issue the next lower entry, compare it next cycle
				cmp_idx_q <= addr_q;
				if (addr_q != '0) begin
					addr_q <= addr_q - 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/ndlm_chk.sv -----
// Port-level checker for the name directory, bound to the top level.
// Depends on name_directory_last_match_lookup_core.
module ndlm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [71:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in work at a time
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result waits");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[10:1] == 10'd0)
		else $error("index set without a match");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[22] && (m_tdata[10:1] < m_tdata[21:11]))
		else $error("match index outside held entries");

endmodule

bind name_directory_last_match_lookup_core ndlm_chk u_ndlm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
